FILE: src/sector_interleave_map_core_assert.svh
// ----------------------------------------------------------------------------
// sector interleave map assertion macros
// shared property forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SECTOR_INTERLEAVE_MAP_CORE_ASSERT_SVH
`define SECTOR_INTERLEAVE_MAP_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SIM_CHECK_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sim: same-cycle check failed");

// next-cycle implication
`define SIM_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sim: next-cycle check failed");

`endif

FILE: src/sim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_pkg
// widths, codes and shared types of the sector interleave map
// ----------------------------------------------------------------------------
package sim_pkg;

    localparam int SECT_W          = 6;
    localparam int INTLV_W         = 5;
    localparam int FLAG_W          = 8;
    localparam int SLOT_W          = 6;
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 3;
    localparam int MAX_SECTORS_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [FLAG_W-1:0]  FLAG_GOOD   = 8'h00;
    localparam logic [FLAG_W-1:0]  FLAG_BAD    = 8'h80;
    localparam logic [SECT_W-1:0]  SPT_RESET   = 6'd17;
    localparam logic [INTLV_W-1:0] INTLV_RESET = 5'd3;

    typedef enum logic {
        REG_SPT   = 1'b0,
        REG_INTLV = 1'b1
    } sim_reg_t;

    typedef struct packed {
        logic [SECT_W-1:0] n;
        logic              bad;
    } sim_job_t;

endpackage

FILE: src/sim_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim channel interfaces
// request and result channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface sim_req_if;
    import sim_pkg::*;

    logic valid;
    logic ready;
    logic mark_bad;

    modport source (output valid, output mark_bad, input ready);
    modport sink   (input valid, input mark_bad, output ready);
endinterface

interface sim_res_if;
    import sim_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic [FLAG_W-1:0] flag_byte;
    logic [SECT_W-1:0] logical_sector;
    logic              last;

    modport source (output valid, output slot, output flag_byte, output logical_sector,
                    output last, input ready);
    modport sink   (input valid, input slot, input flag_byte, input logical_sector,
                    input last, output ready);
endinterface

FILE: src/sim_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_front
// register file, request intake and job classification
// ----------------------------------------------------------------------------
module sim_front #(
    parameter int MAX_SECTORS = sim_pkg::MAX_SECTORS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sim_pkg::ADDR_W-1:0]   paddr,
    input  logic [sim_pkg::DATA_W-1:0]   pwdata,
    output logic [sim_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    sim_req_if.sink                      req,
    output logic                         job_valid,
    output sim_pkg::sim_job_t            job,
    input  logic                         q_full,
    output logic [sim_pkg::INTLV_W-1:0]  interleave
);
    import sim_pkg::*;

    localparam int CLAMP = (MAX_SECTORS < 63) ? MAX_SECTORS : 63;
    localparam logic [SECT_W-1:0] CLAMP_N = CLAMP[SECT_W-1:0];

    logic [SECT_W-1:0]  spt_reg;
    logic [INTLV_W-1:0] intlv_reg;
    sim_reg_t           reg_sel;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_sel = sim_reg_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg   <= SPT_RESET;
            intlv_reg <= INTLV_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_SPT:   spt_reg   <= pwdata[SECT_W-1:0];
                REG_INTLV: intlv_reg <= pwdata[INTLV_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SPT:   prdata = DATA_W'(spt_reg);
            REG_INTLV: prdata = DATA_W'(intlv_reg);
            default:   prdata = '0;
        endcase
    end

    assign interleave = intlv_reg;

    // a word is taken whenever the queue has room
    assign req.ready = !q_full;
    assign job_valid = req.valid && !q_full;
    assign job.n     = (spt_reg > CLAMP_N) ? CLAMP_N : spt_reg;
    assign job.bad   = req.mark_bad;

endmodule

FILE: src/sim_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_queue
// short job fifo between intake and table builder
// ----------------------------------------------------------------------------
module sim_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sim_pkg::sim_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output sim_pkg::sim_job_t q_job
);
    import sim_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    sim_job_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == DEPTH_N);
    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: src/sim_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_back
// places logical sectors into slots, then streams the table out
// ----------------------------------------------------------------------------
module sim_back #(
    parameter int MAX_SECTORS = sim_pkg::MAX_SECTORS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  sim_pkg::sim_job_t           q_job,
    output logic                        q_pop,
    input  logic [sim_pkg::INTLV_W-1:0] interleave,
    sim_res_if.source                   res,
    output logic                        busy
);
    import sim_pkg::*;

    localparam int DEPTH = (MAX_SECTORS < 63) ? MAX_SECTORS : 63;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = SECT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_RD,
        ST_LD
    } state_t;

    state_t            state_reg;
    logic [SECT_W-1:0] n_reg;
    logic              bad_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [SECT_W-1:0] sec_reg;
    logic [DEPTH-1:0]  used_reg;
    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [FLAG_W-1:0] out_flag_reg;
    logic [SECT_W-1:0] out_sect_reg;
    logic              out_last_reg;

    logic [SECT_W-1:0] sector_mem [DEPTH];
    logic [SECT_W-1:0] rd_data_reg;

    logic [SUM_W-1:0]  n_ext;
    logic [SUM_W-1:0]  step_sum;
    logic [SUM_W-1:0]  inc_sum;
    logic [IDX_W-1:0]  step_pos;
    logic [IDX_W-1:0]  inc_pos;
    logic              slot_free;
    logic              mem_we;
    logic              rd_en;
    logic              out_free;
    logic              emit_last;

    assign n_ext     = SUM_W'(n_reg);
    assign step_sum  = SUM_W'(pos_reg) + SUM_W'(interleave);
    assign inc_sum   = SUM_W'(pos_reg) + SUM_W'(1);
    // overshoot of the track restarts at slot zero
    assign step_pos  = (step_sum >= n_ext) ? '0 : step_sum[IDX_W-1:0];
    assign inc_pos   = (inc_sum >= n_ext) ? '0 : inc_sum[IDX_W-1:0];
    assign slot_free = !used_reg[pos_reg];
    assign mem_we    = (state_reg == ST_BUILD) && slot_free;
    assign rd_en     = (state_reg == ST_RD);
    assign out_free  = !out_valid_reg || res.ready;
    assign emit_last = (inc_sum == n_ext);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign busy      = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            sector_mem[pos_reg] <= sec_reg;
        if (rd_en)
            rd_data_reg <= sector_mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            bad_reg       <= 1'b0;
            pos_reg       <= '0;
            sec_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_slot_reg  <= '0;
            out_flag_reg  <= '0;
            out_sect_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (res.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        n_reg    <= q_job.n;
                        bad_reg  <= q_job.bad;
                        used_reg <= '0;
                        pos_reg  <= '0;
                        sec_reg  <= SECT_W'(1);
                        // an empty track gives no words
                        state_reg <= (q_job.n == '0) ? ST_IDLE : ST_BUILD;
                    end
                end
                ST_BUILD:
                begin
                    if (!slot_free)
                        pos_reg <= inc_pos;
                    else
                    begin
                        used_reg[pos_reg] <= 1'b1;
                        sec_reg           <= sec_reg + 1'b1;
                        if (sec_reg == n_reg)
                        begin
                            pos_reg   <= '0;
                            state_reg <= ST_RD;
                        end
                        else
                            pos_reg <= step_pos;
                    end
                end
                ST_RD:
                    state_reg <= ST_LD;
                ST_LD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_slot_reg  <= SLOT_W'(pos_reg);
                        out_flag_reg  <= bad_reg ? FLAG_BAD : FLAG_GOOD;
                        out_sect_reg  <= rd_data_reg;
                        out_last_reg  <= emit_last;
                        pos_reg       <= inc_pos;
                        state_reg     <= emit_last ? ST_IDLE : ST_RD;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.slot           = out_slot_reg;
    assign res.flag_byte      = out_flag_reg;
    assign res.logical_sector = out_sect_reg;
    assign res.last           = out_last_reg;

endmodule

FILE: src/sector_interleave_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_interleave_map_core
// builds the interleaved sector table of one track per request word
// ----------------------------------------------------------------------------
// channel  | role   | handshake      | payload
// req      | sink   | valid/ready    | mark_bad
// res      | source | valid/ready    | slot, flag_byte, logical_sector, last
// apb      | slave  | psel/penable   | sectors_per_track @0x0, interleave @0x4
//
// a request yields n result words, n = min(sectors_per_track, MAX_SECTORS)
// after the job is taken, build either places a sector or walks the single slot
// pointer past an occupied slot, then each word passes a read and a load state
// through the one-port slot memory
// reset clears the used map and all control state at once, no clearing pass
// the two-entry job queue and the output register let each side stall alone
// ----------------------------------------------------------------------------
`include "sector_interleave_map_core_assert.svh"

module sector_interleave_map_core #(
    parameter int MAX_SECTORS = sim_pkg::MAX_SECTORS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sim_pkg::ADDR_W-1:0] paddr,
    input  logic [sim_pkg::DATA_W-1:0] pwdata,
    output logic [sim_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    sim_req_if.sink                    req,
    sim_res_if.source                  res
);
    import sim_pkg::*;

    logic               job_valid;
    sim_job_t           job;
    logic               q_full;
    logic               q_valid;
    sim_job_t           q_job;
    logic               q_pop;
    logic [INTLV_W-1:0] interleave;
    logic               back_busy;

    sim_front #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req        (req),
        .job_valid  (job_valid),
        .job        (job),
        .q_full     (q_full),
        .interleave (interleave)
    );

    sim_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    sim_back #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .q_pop      (q_pop),
        .interleave (interleave),
        .res        (res),
        .busy       (back_busy)
    );

    // the last word may be loaded at the same edge the one before it leaves
    `SIM_CHECK_IMPLY(a_push_room, job_valid, !q_full)
    `SIM_CHECK_IMPLY(a_pop_valid, q_pop, q_valid)
    `SIM_CHECK_IMPLY(a_sector_set, res.valid, res.logical_sector != '0)
    `SIM_CHECK_NEXT(a_table_open, res.valid && res.ready && !res.last, back_busy || res.valid)

endmodule

FILE: sim/sector_interleave_map_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_interleave_map_core_test
// self-checking bench: a table of directed track requests, then random
// geometry phases; every result word is checked against a slot plan built
// from the current geometry, with random idling on both channels
// ----------------------------------------------------------------------------
module sector_interleave_map_core_test;
    import sim_pkg::*;

    localparam int MAX_TRACK     = MAX_SECTORS_DEF;
    localparam int ITEM_TOTAL    = 460;
    localparam int CALM_FROM     = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 20000;
    localparam int ROW_COUNT     = 24;

    typedef enum logic {
        ROW_PLANNED,
        ROW_IN_ORDER
    } row_kind_t;

    typedef struct packed {
        logic [SECT_W-1:0]  spt;
        logic [INTLV_W-1:0] intlv;
        logic               bad;
        row_kind_t          kind;
    } track_row_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [FLAG_W-1:0] flag;
        logic [SECT_W-1:0] sector;
        logic              last;
    } slot_entry_t;

    // in-order rows: one step, no step, or a step of the whole track or more all
    // fill the slots in sequence; zero sectors gives no word at all
    localparam track_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{6'd17, 5'd3,  1'b0, ROW_PLANNED},
        '{6'd17, 5'd3,  1'b1, ROW_PLANNED},
        '{6'd1,  5'd3,  1'b0, ROW_IN_ORDER},
        '{6'd1,  5'd0,  1'b1, ROW_IN_ORDER},
        '{6'd0,  5'd0,  1'b0, ROW_IN_ORDER},
        '{6'd0,  5'd31, 1'b1, ROW_IN_ORDER},
        '{6'd2,  5'd1,  1'b0, ROW_IN_ORDER},
        '{6'd2,  5'd2,  1'b1, ROW_IN_ORDER},
        '{6'd63, 5'd1,  1'b0, ROW_IN_ORDER},
        '{6'd63, 5'd0,  1'b1, ROW_IN_ORDER},
        '{6'd63, 5'd31, 1'b0, ROW_PLANNED},
        '{6'd63, 5'd17, 1'b1, ROW_PLANNED},
        '{6'd16, 5'd16, 1'b0, ROW_IN_ORDER},
        '{6'd16, 5'd31, 1'b1, ROW_IN_ORDER},
        '{6'd16, 5'd15, 1'b0, ROW_PLANNED},
        '{6'd8,  5'd3,  1'b1, ROW_PLANNED},
        '{6'd9,  5'd3,  1'b0, ROW_PLANNED},
        '{6'd10, 5'd4,  1'b1, ROW_PLANNED},
        '{6'd12, 5'd5,  1'b0, ROW_PLANNED},
        '{6'd32, 5'd2,  1'b1, ROW_PLANNED},
        '{6'd31, 5'd30, 1'b0, ROW_PLANNED},
        '{6'd5,  5'd31, 1'b1, ROW_IN_ORDER},
        '{6'd40, 5'd7,  1'b0, ROW_PLANNED},
        '{6'd3,  5'd2,  1'b1, ROW_PLANNED}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    sim_req_if req_ch ();
    sim_res_if res_ch ();

    logic [SECT_W-1:0]  spt_mirror   = SPT_RESET;
    logic [INTLV_W-1:0] intlv_mirror = INTLV_RESET;
    slot_entry_t        slot_plan_q [$];
    int unsigned        fault_count  = 0;
    int unsigned        quiet_cycles = 0;
    bit                 calm         = 1'b0;

    sector_interleave_map_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    always #5 clk = ~clk;

    // expected words of one track, in physical slot order
    function automatic void plan_track(input logic bad, input bit in_order);
        bit                taken [MAX_TRACK];
        logic [SECT_W-1:0] owner [MAX_TRACK];
        int unsigned       n;
        int unsigned       pos;
        slot_entry_t       e;
        n = spt_mirror;
        pos = 0;
        taken = '{default: 1'b0};
        if (in_order)
        begin
            for (int unsigned s = 0; s < n; s++)
                owner[s] = SECT_W'(s + 1);
        end
        else
        begin
            for (int unsigned sec = 1; sec <= n; sec++)
            begin
                if (pos >= n)
                    pos = 0;
                while (taken[pos])
                begin
                    pos++;
                    if (pos >= n)
                        pos = 0;
                end
                taken[pos] = 1'b1;
                owner[pos] = SECT_W'(sec);
                pos += intlv_mirror;
            end
        end
        for (int unsigned s = 0; s < n; s++)
        begin
            e.slot   = SLOT_W'(s);
            e.flag   = bad ? FLAG_BAD : FLAG_GOOD;
            e.sector = owner[s];
            e.last   = (s + 1 == n);
            slot_plan_q.push_back(e);
        end
    endfunction

    function automatic void check_field(input string name, input logic [FLAG_W-1:0] want,
                                        input logic [FLAG_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fault_count++;
        end
    endfunction

    task automatic apb_access(input logic wr, input sim_reg_t idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // lower the request, wait out every expected word and the zero-sector jobs
    task automatic settle_track();
        req_ch.valid <= 1'b0;
        while (slot_plan_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [SECT_W-1:0] n, input logic [INTLV_W-1:0] step);
        logic [DATA_W-1:0] junk;
        logic [DATA_W-1:0] back;
        settle_track();
        junk = $urandom;
        apb_access(1'b1, REG_SPT, {junk[DATA_W-1:SECT_W], n}, back);
        spt_mirror = n;
        apb_access(1'b0, REG_SPT, junk, back);
        check_field("sectors_per_track readback", 8'(n), 8'(back));
        if (back[DATA_W-1:FLAG_W] !== '0)
        begin
            $display("%0t: sectors_per_track readback upper expected 0 got %0h",
                     $time, back[DATA_W-1:FLAG_W]);
            fault_count++;
        end
        junk = $urandom;
        apb_access(1'b1, REG_INTLV, {junk[DATA_W-1:INTLV_W], step}, back);
        intlv_mirror = step;
        apb_access(1'b0, REG_INTLV, junk, back);
        check_field("interleave readback", 8'(step), 8'(back));
        if (back[DATA_W-1:FLAG_W] !== '0)
        begin
            $display("%0t: interleave readback upper expected 0 got %0h",
                     $time, back[DATA_W-1:FLAG_W]);
            fault_count++;
        end
    endtask

    task automatic send_track_req(input logic bad, input bit in_order);
        req_ch.valid    <= 1'b1;
        req_ch.mark_bad <= bad;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        plan_track(bad, in_order);
    endtask

    task automatic source_gap();
        int unsigned span;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            span = $urandom_range(1, 16);
            repeat (span) @(posedge clk);
        end
    endtask

    initial
    begin : res_pacing
        int unsigned span;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                span = $urandom_range(1, 16);
                repeat (span) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            span = $urandom_range(1, 24);
            repeat (span) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : word_check
        slot_entry_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (slot_plan_q.size() == 0)
            begin
                $display("%0t: word with nothing expected: slot %0d flag %0h sector %0d last %0b",
                         $time, res_ch.slot, res_ch.flag_byte, res_ch.logical_sector,
                         res_ch.last);
                fault_count++;
            end
            else
            begin
                want = slot_plan_q.pop_front();
                check_field("slot", 8'(want.slot), 8'(res_ch.slot));
                check_field("flag_byte", want.flag, res_ch.flag_byte);
                check_field("logical_sector", 8'(want.sector), 8'(res_ch.logical_sector));
                check_field("last", 8'(want.last), 8'(res_ch.last));
            end
        end
    end

    // a long track build is the longest quiet stretch, well under the limit
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("sector_interleave_map_core_test: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned        sent;
        int unsigned        roll;
        int unsigned        phase_len;
        logic [SECT_W-1:0]  n_pick;
        logic [INTLV_W-1:0] step_pick;
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.mark_bad = 1'b0;
        res_ch.ready    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run on the reset geometry
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            if (DIRECTED_ROWS[i].spt != spt_mirror || DIRECTED_ROWS[i].intlv != intlv_mirror)
                set_geometry(DIRECTED_ROWS[i].spt, DIRECTED_ROWS[i].intlv);
            send_track_req(DIRECTED_ROWS[i].bad, DIRECTED_ROWS[i].kind == ROW_IN_ORDER);
            source_gap();
        end

        // mostly short tracks, a few long ones and a few empty ones
        sent = ROW_COUNT;
        while (sent < ITEM_TOTAL)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                n_pick = '0;
            else if (roll < 12)
                n_pick = SECT_W'($urandom_range(40, 63));
            else
                n_pick = SECT_W'($urandom_range(1, 16));
            roll = $urandom_range(0, 99);
            if (roll < 10)
                step_pick = '0;
            else if (roll < 25)
                step_pick = INTLV_W'($urandom_range(17, 31));
            else
                step_pick = INTLV_W'($urandom_range(1, 17));
            phase_len = (n_pick >= 40) ? $urandom_range(1, 3) : $urandom_range(4, 16);
            set_geometry(n_pick, step_pick);
            repeat (phase_len)
            begin
                if (sent < ITEM_TOTAL)
                begin
                    calm = (sent >= CALM_FROM);
                    send_track_req(1'($urandom_range(0, 1)), 1'b0);
                    source_gap();
                    sent++;
                end
            end
        end

        settle_track();
        if (fault_count == 0)
            $display("sector_interleave_map_core_test: clean");
        else
            $display("sector_interleave_map_core_test: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/sim_pkg.sv
src/sim_ifs.sv
src/sim_front.sv
src/sim_queue.sv
src/sim_back.sv
src/sector_interleave_map_core.sv
sim/sector_interleave_map_core_test.sv
